/* hw/rtl/f8e4m3_pkg.sv */
// Package for the fp32 to E4M3 converter: shared types and constants.
// Used by f8e4m3_round and fp32_to_fp8_e4m3; depends on nothing.
package f8e4m3_pkg;

  localparam logic [7:0]  F32ExpAll1  = 8'hFF;
  localparam logic [6:0]  NanMag      = 7'h7F;
  localparam logic [6:0]  MaxMag      = 7'h7E;
  localparam logic [6:0]  MinNorm     = 7'h08;
  localparam logic [22:0] SatFracAt8  = 23'h600000;

  // Result class decided in the first stage.
  typedef enum logic [2:0] {
    ClsZero,
    ClsNan,
    ClsSat,
    ClsNorm,
    ClsSub
  } cls_e;

  // Stage one to stage two payload.
  typedef struct packed {
    logic        sgn;
    cls_e        cls;
    logic [7:0]  ex;
    logic [22:0] fr;
  } dec_t;

  // Stage two to stage three payload: value to round and its sticky bits.
  typedef struct packed {
    logic        sgn;
    cls_e        cls;
    logic [3:0]  eo;
    logic [3:0]  kept;   // kept bits plus guard (sub) or mantissa plus guard
    logic        sticky;
  } aln_t;

endpackage

/* hw/rtl/f8e4m3_round.sv */
// Final stage logic: round to nearest even and pack the E4M3 code.
// Depends on f8e4m3_pkg.
module f8e4m3_round (
  input  f8e4m3_pkg::aln_t a_i,
  output logic [7:0]       code_o
);

  logic [3:0] m;
  logic       up;
  logic [4:0] eo;
  logic [6:0] mag;

  // Rounding and carry handling.
  always_comb begin
    up  = a_i.kept[0] & (a_i.sticky | a_i.kept[1]);
    m   = {1'b0, a_i.kept[3:1]} + {3'b000, up};
    eo  = {1'b0, a_i.eo};
    mag = 7'd0;
    unique case (a_i.cls)
      f8e4m3_pkg::ClsNan:  mag = f8e4m3_pkg::NanMag;
      f8e4m3_pkg::ClsSat:  mag = f8e4m3_pkg::MaxMag;
      f8e4m3_pkg::ClsZero: mag = 7'd0;
      f8e4m3_pkg::ClsSub: begin
        mag = m[3] ? f8e4m3_pkg::MinNorm : {4'd0, m[2:0]};
      end
      f8e4m3_pkg::ClsNorm: begin
        if (m[3]) begin
          eo = eo + 5'd1;
        end
        if (eo > 5'd15) begin
          mag = f8e4m3_pkg::MaxMag;
        end else if (eo == 5'd15 && m[2:0] == 3'd7) begin
          mag = f8e4m3_pkg::MaxMag;
        end else begin
          mag = {eo[3:0], m[2:0]};
        end
      end
      default: mag = 7'd0;
    endcase
  end

  assign code_o = {a_i.sgn, mag};

endmodule

/* hw/rtl/fp32_to_fp8_e4m3.sv */
// Top level of the fp32 to E4M3 saturating converter, a three-stage pipeline.
// Depends on f8e4m3_pkg and f8e4m3_round.
//
//  channel | dir | fields
//  s_axis  | in  | tdata[31:0] = fp32_bits
//  m_axis  | out | tdata[7:0]  = fp8_code
//
// One beat enters per cycle unless a stall has filled every stage.
// Stages: classify, align with sticky, round and pack into the output register.
// Reset clears the valid bits only. A stall freezes each full stage back from the output
// to the nearest bubble, while that bubble is still filled.
module fp32_to_fp8_e4m3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] fp32_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [7:0] fp8_code
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  f8e4m3_pkg::dec_t dec_d, dec_q;
  f8e4m3_pkg::aln_t aln_d, aln_q;
  logic [7:0] code_d, code_q;

  // Pipeline advance: a stage loads when it is empty or when the one after it loads.
  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  // Stage one: classify.
  always_comb begin
    dec_d.sgn = s_axis_tdata_i[31];
    dec_d.ex  = s_axis_tdata_i[30:23];
    dec_d.fr  = s_axis_tdata_i[22:0];
    if (dec_d.ex == f8e4m3_pkg::F32ExpAll1) begin
      dec_d.cls = f8e4m3_pkg::ClsNan;
    end else if (dec_d.ex == 8'd0) begin
      dec_d.cls = f8e4m3_pkg::ClsZero;
    end else if (dec_d.ex >= 8'd136 ||
                 (dec_d.ex == 8'd135 && dec_d.fr >= f8e4m3_pkg::SatFracAt8)) begin
      dec_d.cls = f8e4m3_pkg::ClsSat;
    end else if (dec_d.ex >= 8'd121) begin
      dec_d.cls = f8e4m3_pkg::ClsNorm;
    end else if (dec_d.ex >= 8'd110) begin
      // Drop count 14 - e stays at or below 31.
      dec_d.cls = f8e4m3_pkg::ClsSub;
    end else begin
      dec_d.cls = f8e4m3_pkg::ClsZero;
    end
  end

  // Stage two: align onto the target grid and collect the sticky bits.
  logic [5:0]  drop;
  logic [23:0] sig;
  logic [3:0]  shr;
  logic [23:0] lost;
  always_comb begin
    sig  = {1'b1, dec_q.fr};
    drop = 6'(8'd141 - dec_q.ex);    // 14 - e, 21..31 for subnormals
    shr  = 4'(sig >> (drop - 6'd1));
    lost = sig & ~(24'hFFFFFF << (drop - 6'd1));
    aln_d.sgn = dec_q.sgn;
    aln_d.cls = dec_q.cls;
    aln_d.eo  = 4'(dec_q.ex - 8'd120);
    if (dec_q.cls == f8e4m3_pkg::ClsSub) begin
      aln_d.kept   = shr;
      aln_d.sticky = (lost != 24'd0);
    end else begin
      aln_d.kept   = dec_q.fr[22:19];
      aln_d.sticky = (dec_q.fr[18:0] != 19'd0);
    end
  end

  // Stage three: round and pack.
  f8e4m3_round u_round (
    .a_i    (aln_q),
    .code_o (code_d)
  );

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1) dec_q  <= dec_d;
    if (en2) aln_q  <= aln_d;
    if (en3) code_q <= code_d;
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = code_q;

endmodule
